>>> rtl/block_chain_table_engine_defines.svh
// Assertion macros used by the block chain table engine datapath.
// Each macro expects signals named clk and arst_n in the including scope.
`ifndef BLOCK_CHAIN_TABLE_ENGINE_DEFINES_SVH
`define BLOCK_CHAIN_TABLE_ENGINE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCTE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bcte: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BCTE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bcte: next-cycle check failed");

`endif

>>> rtl/bcte_pkg.sv
`default_nettype none

package bcte_pkg;

	localparam int FIELD_W    = 10;
	localparam int ENTRIES    = 1024;
	localparam int TABLE_SIZE = (ENTRIES < (1 << FIELD_W)) ? ENTRIES : (1 << FIELD_W);
	localparam int ADDR_W     = $clog2(TABLE_SIZE);
	localparam int PTR_W      = FIELD_W + 1;

	localparam logic [PTR_W-1:0]   TABLE_END  = PTR_W'(TABLE_SIZE);
	localparam logic [ADDR_W-1:0]  CLEAR_LAST = ADDR_W'(TABLE_SIZE - 1);
	localparam logic [FIELD_W-1:0] EMPTY_MARK = '0;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_TEST  = 2'd2,
		OP_FIND  = 2'd3
	} bcte_op_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EVAL
	} bcte_state_t;

	typedef struct packed {
		logic accept;
		logic clear;
		logic scan_step;
		logic out_load;
	} bcte_ctl_t;

	typedef struct packed {
		logic clear_last;
		logic finish;
		logic out_free;
	} bcte_sts_t;

endpackage

`default_nettype wire

>>> rtl/bcte_req_if.sv
`default_nettype none

interface bcte_req_if;
	import bcte_pkg::*;

	logic               valid;
	logic               ready;
	bcte_op_t           cmd;
	logic [FIELD_W-1:0] index;
	logic [FIELD_W-1:0] next_value;

	modport source (output valid, output cmd, output index, output next_value, input ready);
	modport sink (input valid, input cmd, input index, input next_value, output ready);

endinterface

`default_nettype wire

>>> rtl/bcte_rsp_if.sv
`default_nettype none

interface bcte_rsp_if;
	import bcte_pkg::*;

	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] result_index;
	logic               is_empty;
	logic               found;
	logic               error;

	modport source (output valid, output result_index, output is_empty, output found,
		output error, input ready);
	modport sink (input valid, input result_index, input is_empty, input found,
		input error, output ready);

endinterface

`default_nettype wire

>>> rtl/bcte_cfg_if.sv
`default_nettype none

interface bcte_cfg_if;
	import bcte_pkg::*;

	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

`default_nettype wire

>>> rtl/bcte_ram.sv
`default_nettype none

module bcte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

>>> rtl/bcte_ctrl.sv
`default_nettype none

module bcte_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output      logic               req_ready,
	input  wire bcte_pkg::bcte_sts_t sts,
	output      bcte_pkg::bcte_ctl_t ctl
);
	import bcte_pkg::*;

	bcte_state_t state_q;
	bcte_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (sts.finish && sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		ctl       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ctl.clear = 1'b1;
			end
			ST_IDLE: begin
				req_ready  = 1'b1;
				ctl.accept = req_valid;
			end
			ST_EVAL: begin
				if (sts.finish) begin
					ctl.out_load = sts.out_free;
				end else begin
					ctl.scan_step = 1'b1;
				end
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/bcte_datapath.sv
`default_nettype none
`include "block_chain_table_engine_defines.svh"

module bcte_datapath (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire bcte_pkg::bcte_ctl_t          ctl,
	output      bcte_pkg::bcte_sts_t          sts,
	input  wire bcte_pkg::bcte_op_t           req_cmd,
	input  wire logic [bcte_pkg::FIELD_W-1:0] req_index,
	input  wire logic [bcte_pkg::FIELD_W-1:0] req_next_value,
	input  wire logic                         cfg_we,
	input  wire logic [bcte_pkg::FIELD_W-1:0] cfg_data,
	bcte_rsp_if.source                        rsp
);
	import bcte_pkg::*;

	logic [FIELD_W-1:0] first_q;
	logic [ADDR_W-1:0]  clr_q;
	bcte_op_t           op_q;
	logic               err_q;
	logic [PTR_W-1:0]   ptr_q;

	logic               idx_ok;
	logic               nxt_ok;
	logic [PTR_W-1:0]   ptr_in;
	logic [PTR_W-1:0]   ptr_next;

	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	logic [FIELD_W-1:0] wr_data;
	logic               rd_en;
	logic [ADDR_W-1:0]  rd_addr;
	logic [FIELD_W-1:0] rd_data;

	logic               in_range;
	logic               entry_empty;
	logic [FIELD_W-1:0] res_index_d;
	logic               is_empty_d;
	logic               found_d;
	logic               error_d;

	logic               out_valid_q;
	logic [FIELD_W-1:0] res_index_q;
	logic               is_empty_q;
	logic               found_q;
	logic               error_q;

	// An index is usable when it is at or above first_index and inside the table.
	assign idx_ok = (req_index >= first_q) && ({1'b0, req_index} < TABLE_END);
	assign nxt_ok = (req_next_value >= first_q) && ({1'b0, req_next_value} < TABLE_END);

	assign ptr_in   = (req_cmd == OP_FIND) ? ({1'b0, req_index} + PTR_W'(1)) : {1'b0, req_index};
	assign ptr_next = ptr_q + PTR_W'(1);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = req_index[ADDR_W-1:0];
		wr_data = req_next_value;
		if (ctl.clear) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = EMPTY_MARK;
		end else if (ctl.accept) begin
			wr_en = idx_ok && nxt_ok && (req_cmd == OP_WRITE);
		end
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = ptr_next[ADDR_W-1:0];
		if (ctl.accept) begin
			rd_en   = idx_ok && (req_cmd != OP_WRITE) && (ptr_in < TABLE_END);
			rd_addr = ptr_in[ADDR_W-1:0];
		end else if (ctl.scan_step) begin
			rd_en = ptr_next < TABLE_END;
		end
	end

	bcte_ram #(
		.WIDTH (FIELD_W),
		.DEPTH (TABLE_SIZE)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
			clr_q   <= '0;
			op_q    <= OP_READ;
			err_q   <= 1'b0;
			ptr_q   <= '0;
		end else begin
			if (cfg_we) begin
				first_q <= cfg_data;
			end
			if (ctl.clear && (clr_q != CLEAR_LAST)) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (ctl.accept) begin
				op_q  <= req_cmd;
				err_q <= !idx_ok || ((req_cmd == OP_WRITE) && !nxt_ok);
				ptr_q <= ptr_in;
			end else if (ctl.scan_step) begin
				ptr_q <= ptr_next;
			end
		end
	end

	assign in_range    = ptr_q < TABLE_END;
	assign entry_empty = rd_data == EMPTY_MARK;

	always_comb begin
		res_index_d = '0;
		is_empty_d  = 1'b0;
		found_d     = 1'b0;
		error_d     = 1'b0;
		if (err_q) begin
			error_d = 1'b1;
		end else begin
			unique case (op_q)
				OP_READ: begin
					res_index_d = rd_data;
				end
				OP_WRITE: begin
					res_index_d = '0;
				end
				OP_TEST: begin
					is_empty_d = entry_empty;
				end
				OP_FIND: begin
					found_d = in_range && entry_empty;
					if (found_d) begin
						res_index_d = ptr_q[FIELD_W-1:0];
					end
				end
				default: begin
					error_d = 1'b0;
				end
			endcase
		end
	end

	assign sts.clear_last = clr_q == CLEAR_LAST;
	assign sts.finish     = err_q || (op_q != OP_FIND) || !in_range || entry_empty;
	assign sts.out_free   = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			res_index_q <= res_index_d;
			is_empty_q  <= is_empty_d;
			found_q     <= found_d;
			error_q     <= error_d;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.result_index = res_index_q;
	assign rsp.is_empty     = is_empty_q;
	assign rsp.found        = found_q;
	assign rsp.error        = error_q;

	`BCTE_ASSERT_NOW(a_load_into_free_slot, ctl.out_load, sts.out_free)
	`BCTE_ASSERT_NEXT(a_load_shows_valid, ctl.out_load, rsp.valid)
	`BCTE_ASSERT_NOW(a_scan_only_on_full_entry, ctl.scan_step, in_range && !entry_empty && !err_q)
	`BCTE_ASSERT_NOW(a_error_clears_fields, rsp.valid && rsp.error,
		(rsp.result_index == '0) && !rsp.found && !rsp.is_empty)

endmodule

`default_nettype wire

>>> rtl/block_chain_table_engine.sv
// Block chain table engine: a table of next-block pointers, one per data block.
// The req channel carries one request per transaction: read next, write next,
// test empty, or find the first empty entry above the given index. The rsp
// channel returns exactly one result transaction per request, in order. The
// cfg channel writes first_index; it is always ready and should only be used
// while no request is outstanding.
// Reads, writes and tests are accepted in the idle state, which issues the table
// access, and finish in the eval state on the registered read data. A search
// also steps over every full entry in the eval state, since the scan reads the
// single table read port once per cycle.
// After reset the controller sweeps all 1024 entries to zero, one per cycle, so
// req is not ready until the sweep ends; cfg writes are taken meanwhile.
// Results sit in an output register. If the receiver stalls, the engine can
// still accept and process the next request, and holds its result until the
// output register is taken.
`default_nettype none

module block_chain_table_engine (
	input  wire logic clk,
	input  wire logic arst_n,
	bcte_req_if.sink   req,
	bcte_rsp_if.source rsp,
	bcte_cfg_if.sink   cfg
);
	import bcte_pkg::*;

	bcte_ctl_t ctl;
	bcte_sts_t sts;
	logic      req_ready;

	assign req.ready = req_ready;
	assign cfg.ready = 1'b1;

	bcte_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	bcte_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.sts            (sts),
		.req_cmd        (req.cmd),
		.req_index      (req.index),
		.req_next_value (req.next_value),
		.cfg_we         (cfg.valid),
		.cfg_data       (cfg.data),
		.rsp            (rsp)
	);

endmodule

`default_nettype wire
